/* sv/bcg_pkg.sv */
// Package for the button click gesture classifier.
// Holds the event, mode, action and register index codes and the bundles
// shared by the classifier modules. No dependencies.
`default_nettype none

package bcg_pkg;

   localparam int CFG_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RESET = 16'd300;
   localparam logic [CFG_DATA_BITS-1:0] DOUBLE_CLICK_RESET = 16'd300;

   typedef enum logic [1:0] {
      EVT_TICK    = 2'd0,
      EVT_PRESS   = 2'd1,
      EVT_RELEASE = 2'd2,
      EVT_OTHER   = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_PRESSED  = 2'd1,
      MODE_RELEASED = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_START  = 3'd1,
      ACT_PAUSE  = 3'd2,
      ACT_RESUME = 3'd3,
      ACT_NEXT   = 3'd4,
      ACT_PREV   = 3'd5
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LONG_PRESS   = 1'd0,
      CSR_DOUBLE_CLICK = 1'd1
   } csr_index_type;

   typedef struct packed {
      event_kind_type kind;
      logic           started;
      logic           paused;
   } event_type;

   typedef struct packed {
      logic [CFG_DATA_BITS-1:0] long_press_ms;
      logic [CFG_DATA_BITS-1:0] double_click_ms;
   } cfg_type;

endpackage

`default_nettype wire

/* sv/bcg_req_if.sv */
// Input channel of the gesture classifier: one button event per transfer.
// No dependencies.
`default_nettype none

interface bcg_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic       player_started;
   logic       player_paused;

   modport source (output valid, output event_kind, output player_started,
                   output player_paused, input ready);
   modport sink (input valid, input event_kind, input player_started,
                 input player_paused, output ready);
endinterface

`default_nettype wire

/* sv/bcg_rsp_if.sv */
// Result channel of the gesture classifier: one action code per transfer.
// No dependencies.
`default_nettype none

interface bcg_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;

   modport source (output valid, output action, input ready);
   modport sink (input valid, input action, output ready);
endinterface

`default_nettype wire

/* sv/bcg_csr_if.sv */
// Configuration write channel of the gesture classifier.
// No dependencies.
`default_nettype none

interface bcg_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/bcg_fsm.sv */
// Gesture state machine: mode, saturating millisecond counter and action decode.
// Depends on bcg_pkg.
`default_nettype none

module bcg_fsm #(
   parameter int COUNTER_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire bcg_pkg::event_type evt,
   input  wire bcg_pkg::cfg_type   cfg,
   output bcg_pkg::action_type     action
);
   import bcg_pkg::*;

   localparam int CMP_BITS = (COUNTER_BITS > CFG_DATA_BITS) ? COUNTER_BITS : CFG_DATA_BITS;

   mode_type                mode_ff;
   mode_type                mode_in;
   logic [COUNTER_BITS-1:0] elapsed_ff;
   logic [COUNTER_BITS-1:0] elapsed_in;
   logic [COUNTER_BITS-1:0] elapsed_inc;
   logic                    window_end;
   logic                    long_press;

   assign elapsed_inc = elapsed_ff + COUNTER_BITS'(!(&elapsed_ff));
   assign window_end  = CMP_BITS'(elapsed_inc) >= CMP_BITS'(cfg.double_click_ms);
   assign long_press  = CMP_BITS'(elapsed_ff) > CMP_BITS'(cfg.long_press_ms);

   always_comb begin
      mode_in    = mode_ff;
      elapsed_in = elapsed_ff;
      case (evt.kind)
         EVT_TICK: begin
            if (mode_ff == MODE_PRESSED) begin
               elapsed_in = elapsed_inc;
            end else if (mode_ff == MODE_RELEASED) begin
               if (window_end) begin
                  mode_in    = MODE_IDLE;
                  elapsed_in = '0;
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
         end
         EVT_PRESS: begin
            if (mode_ff == MODE_PRESSED) begin
               mode_in = MODE_PRESSED;
            end else if (mode_ff == MODE_RELEASED) begin
               mode_in    = MODE_IDLE;
               elapsed_in = '0;
            end else begin
               mode_in    = MODE_PRESSED;
               elapsed_in = '0;
            end
         end
         EVT_RELEASE: begin
            if (mode_ff == MODE_PRESSED) begin
               mode_in    = long_press ? MODE_IDLE : MODE_RELEASED;
               elapsed_in = '0;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_comb begin
      action = ACT_NONE;
      case (evt.kind)
         EVT_TICK: begin
            if (mode_ff == MODE_RELEASED && window_end) begin
               if (!evt.started) begin
                  action = ACT_START;
               end else if (!evt.paused) begin
                  action = ACT_PAUSE;
               end else begin
                  action = ACT_RESUME;
               end
            end
         end
         EVT_PRESS: begin
            if (mode_ff == MODE_RELEASED) begin
               action = ACT_NEXT;
            end
         end
         EVT_RELEASE: begin
            if (mode_ff == MODE_PRESSED && long_press) begin
               action = ACT_PREV;
            end
         end
         default: begin
            action = ACT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         elapsed_ff <= '0;
      end else if (step) begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (mode_ff == MODE_IDLE && elapsed_ff == '0))
      else $error("state not cleared by reset");

   a_idle_counter_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (elapsed_ff == '0))
      else $error("counter not zero while idle");

   a_gesture_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (step && action != ACT_NONE) |=> (mode_ff == MODE_IDLE))
      else $error("mode not idle after a gesture");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(mode_ff) && $stable(elapsed_ff)))
      else $error("state changed without an accepted event");

endmodule

`default_nettype wire

/* sv/button_click_gesture_classifier.sv */
// The action for an event is registered and offered in the cycle after its transfer.
// Throughput: one event per cycle; the output register lets a new event in
// while the previous action waits, as long as that action is taken the same cycle.
// Reset clears the mode, the counter and the output valid, and sets both
// timing registers to 300 ms. Depends on bcg_pkg, bcg_fsm and the channel interfaces.
`default_nettype none

module button_click_gesture_classifier #(
   parameter int COUNTER_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   bcg_req_if.sink   req,
   bcg_rsp_if.source rsp,
   bcg_csr_if.sink   csr
);
   import bcg_pkg::*;

   logic       rsp_valid_ff;
   action_type action_ff;
   action_type action;
   logic       step;
   cfg_type    cfg_ff;
   event_type  evt;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign step      = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign evt.kind    = event_kind_type'(req.event_kind);
   assign evt.started = req.player_started;
   assign evt.paused  = req.player_paused;

   bcg_fsm #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .evt   (evt),
      .cfg   (cfg_ff),
      .action(action)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms   <= LONG_PRESS_RESET;
         cfg_ff.double_click_ms <= DOUBLE_CLICK_RESET;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_LONG_PRESS:   cfg_ff.long_press_ms <= csr.data;
            CSR_DOUBLE_CLICK: cfg_ff.double_click_ms <= csr.data;
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req.ready) begin
         rsp_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         action_ff <= action;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.action = action_ff;

endmodule

`default_nettype wire

/* test/tb_gesture_pkg.sv */
// Scoreboard for the button click gesture classifier testbench.
// Predicts the action for every accepted button event and checks each returned action.
// Depends on bcg_pkg.
package tb_gesture_pkg;
   import bcg_pkg::*;

   class gesture_scoreboard;
      logic [CFG_DATA_BITS-1:0] long_ms;
      logic [CFG_DATA_BITS-1:0] double_ms;
      mode_type                 mode;
      logic [15:0]              elapsed;
      action_type               expected_actions[$];
      int                       action_hits[6];
      int                       events_seen;
      int                       errors;

      function new();
         long_ms = LONG_PRESS_RESET;
         double_ms = DOUBLE_CLICK_RESET;
         mode = MODE_IDLE;
         elapsed = '0;
         events_seen = 0;
         errors = 0;
         foreach (action_hits[i]) action_hits[i] = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CFG_DATA_BITS-1:0] value);
         case (idx)
            CSR_LONG_PRESS: long_ms = value;
            CSR_DOUBLE_CLICK: double_ms = value;
            default: ;
         endcase
      endfunction

      function void count_ms();
         if (elapsed != '1) elapsed++;
      endfunction

      function void note_event(event_kind_type kind, logic started, logic paused);
         action_type act;
         act = ACT_NONE;
         events_seen++;
         case (kind)
            EVT_TICK: begin
               if (mode == MODE_PRESSED) begin
                  count_ms();
               end else if (mode == MODE_RELEASED) begin
                  count_ms();
                  if (elapsed >= double_ms) begin
                     if (!started) act = ACT_START;
                     else if (!paused) act = ACT_PAUSE;
                     else act = ACT_RESUME;
                     mode = MODE_IDLE;
                     elapsed = '0;
                  end
               end
            end
            EVT_PRESS: begin
               if (mode == MODE_IDLE) begin
                  mode = MODE_PRESSED;
                  elapsed = '0;
               end else if (mode == MODE_RELEASED) begin
                  act = ACT_NEXT;
                  mode = MODE_IDLE;
                  elapsed = '0;
               end
            end
            EVT_RELEASE: begin
               if (mode == MODE_PRESSED) begin
                  if (elapsed > long_ms) begin
                     act = ACT_PREV;
                     mode = MODE_IDLE;
                  end else begin
                     mode = MODE_RELEASED;
                  end
                  elapsed = '0;
               end
            end
            default: ;
         endcase
         expected_actions.push_back(act);
      endfunction

      function void check_action(logic [2:0] got);
         action_type want;
         if (expected_actions.size() == 0) begin
            $error("action: no event waiting, expected none, actual %0d", got);
            errors++;
            return;
         end
         want = expected_actions.pop_front();
         if (got !== want) begin
            $error("action: expected %0d (%s), actual %0d", want, want.name(), got);
            errors++;
         end else begin
            action_hits[want]++;
         end
      endfunction
   endclass

endpackage

/* test/tb_top.sv */
// Top-level testbench for button_click_gesture_classifier.
// Drives button events and timing register writes with random idling and checks every
// action against the scoreboard. Depends on bcg_pkg, the channel interfaces and tb_gesture_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bcg_pkg::*;
   import tb_gesture_pkg::*;

   localparam int CYCLE_LIMIT = 50000;
   localparam int PHASE_EVENTS = 220;
   localparam int PHASE_COUNT = 8;

   logic clock = 1'b0;
   logic reset;

   bcg_req_if req_if ();
   bcg_rsp_if rsp_if ();
   bcg_csr_if csr_if ();

   button_click_gesture_classifier dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   gesture_scoreboard sb = new();

   int  req_transfers = 0;
   int  csr_transfers = 0;
   int  cycle_count = 0;
   int  rsp_hold = 0;
   int  settings_used = 0;
   bit  req_gaps = 1'b1;
   bit  rsp_gaps = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) sb.check_action(rsp_if.action);
         if (req_if.valid && req_if.ready) begin
            sb.note_event(event_kind_type'(req_if.event_kind), req_if.player_started,
                          req_if.player_paused);
            req_transfers++;
         end
         if (csr_if.valid && csr_if.ready) begin
            sb.set_register(csr_index_type'(csr_if.index), csr_if.data);
            csr_transfers++;
         end
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_if.ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_if.ready = !(rsp_gaps && $urandom_range(99) < 35);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_event(input event_kind_type kind, input logic started,
                             input logic paused);
      int target;
      while (req_gaps && $urandom_range(99) < 35) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.event_kind = kind;
      req_if.player_started = started;
      req_if.player_paused = paused;
      target = req_transfers + 1;
      do @(negedge clock); while (req_transfers < target);
   endtask

   task automatic send_kind(input event_kind_type kind);
      send_event(kind, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic tick_or_noise();
      if ($urandom_range(99) < 90) send_kind(EVT_TICK);
      else send_kind(event_kind_type'($urandom_range(3)));
   endtask

   task automatic drain();
      req_if.valid = 1'b0;
      while (sb.expected_actions.size() != 0) @(negedge clock);
   endtask

   task automatic write_timing(input csr_index_type idx, input logic [15:0] value);
      int target;
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data = value;
      target = csr_transfers + 1;
      do @(negedge clock); while (csr_transfers < target);
      csr_if.valid = 1'b0;
   endtask

   task automatic set_timing(input logic [15:0] long_value, input logic [15:0] double_value);
      drain();
      write_timing(CSR_LONG_PRESS, long_value);
      write_timing(CSR_DOUBLE_CLICK, double_value);
      settings_used++;
   endtask

   function automatic int span(input int limit_ms);
      return (limit_ms + 2 > 40) ? 40 : limit_ms + 2;
   endfunction

   task automatic play_gesture();
      int hold_ticks;
      int wait_ticks;
      hold_ticks = $urandom_range(span(sb.long_ms), 0);
      wait_ticks = $urandom_range(span(sb.double_ms), 0);
      send_kind(EVT_PRESS);
      repeat (hold_ticks) tick_or_noise();
      send_kind(EVT_RELEASE);
      repeat (wait_ticks) tick_or_noise();
      if ($urandom_range(1)) send_kind(EVT_PRESS);
   endtask

   initial begin
      int unsigned long_set[PHASE_COUNT] = '{1, 2, 4, 65534, 1, 0, 0, 16};
      int unsigned double_set[PHASE_COUNT] = '{1, 2, 3, 1, 65534, 0, 0, 20};
      int          phase_start;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.event_kind = EVT_TICK;
      req_if.player_started = 1'b0;
      req_if.player_paused = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_LONG_PRESS;
      csr_if.data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_event(EVT_OTHER, 1'b1, 1'b1);
      send_event(EVT_TICK, 1'b0, 1'b0);
      send_event(EVT_RELEASE, 1'b0, 1'b0);
      send_event(EVT_PRESS, 1'b0, 1'b0);
      send_event(EVT_PRESS, 1'b1, 1'b0);
      send_event(EVT_OTHER, 1'b0, 1'b1);
      send_event(EVT_TICK, 1'b0, 1'b0);
      send_event(EVT_RELEASE, 1'b0, 1'b0);
      send_event(EVT_RELEASE, 1'b1, 1'b1);
      send_event(EVT_OTHER, 1'b0, 1'b0);
      send_event(EVT_PRESS, 1'b0, 1'b0);

      set_timing(16'd1, 16'd1);
      send_event(EVT_PRESS, 1'b0, 1'b0);
      send_event(EVT_TICK, 1'b0, 1'b0);
      send_event(EVT_TICK, 1'b0, 1'b0);
      send_event(EVT_RELEASE, 1'b0, 1'b0);
      send_event(EVT_PRESS, 1'b0, 1'b0);
      send_event(EVT_TICK, 1'b0, 1'b0);
      send_event(EVT_RELEASE, 1'b0, 1'b0);
      send_event(EVT_TICK, 1'b0, 1'b1);
      send_event(EVT_PRESS, 1'b1, 1'b1);
      send_event(EVT_RELEASE, 1'b1, 1'b1);
      send_event(EVT_TICK, 1'b1, 1'b0);
      send_event(EVT_PRESS, 1'b0, 1'b0);
      send_event(EVT_RELEASE, 1'b0, 1'b0);
      send_event(EVT_TICK, 1'b1, 1'b1);

      // Window and hold limit of 65534, one below the largest 16-bit value.
      set_timing(16'd65534, 16'd65534);
      req_gaps = 1'b0;
      send_kind(EVT_PRESS);
      repeat (40) send_kind(EVT_TICK);
      send_kind(EVT_RELEASE);
      repeat (40) send_kind(EVT_TICK);
      send_kind(EVT_PRESS);
      req_gaps = 1'b1;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_timing(16'(long_set[p] == 0 ? $urandom_range(12, 1) : long_set[p]),
                    16'(double_set[p] == 0 ? $urandom_range(12, 1) : double_set[p]));
         if (p == 1) rsp_hold = 400;
         if (p == 2) begin
            req_gaps = 1'b0;
            rsp_gaps = 1'b0;
         end
         phase_start = req_transfers;
         while (req_transfers - phase_start < PHASE_EVENTS) begin
            if ($urandom_range(99) < 80) begin
               play_gesture();
            end else begin
               repeat ($urandom_range(5, 1)) send_kind(event_kind_type'($urandom_range(3)));
            end
         end
         req_gaps = 1'b1;
         rsp_gaps = 1'b1;
      end

      drain();
      repeat (4) @(negedge clock);
      if (sb.expected_actions.size() != 0) begin
         $error("action: %0d expected actions never arrived", sb.expected_actions.size());
         sb.errors++;
      end
      $display("Checked %0d button events over %0d timing settings, including both extremes;",
               sb.events_seen, settings_used);
      $display("actions seen: start %0d, pause %0d, resume %0d, next %0d, previous %0d.",
               sb.action_hits[ACT_START], sb.action_hits[ACT_PAUSE], sb.action_hits[ACT_RESUME],
               sb.action_hits[ACT_NEXT], sb.action_hits[ACT_PREV]);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
sv/bcg_pkg.sv
sv/bcg_req_if.sv
sv/bcg_rsp_if.sv
sv/bcg_csr_if.sv
sv/bcg_fsm.sv
sv/button_click_gesture_classifier.sv
test/tb_gesture_pkg.sv
test/tb_top.sv
